/* sv/rhsl_pkg.sv */
`timescale 1ns / 1ps

package rhsl_pkg;

  localparam int CH_W      = 8;
  localparam int SUM_W     = 9;
  localparam int SAT_DIV_W = 9;   // 2*den, den <= 255
  localparam int HUE_DIV_W = 12;  // 12*delta, delta <= 255
  localparam int NUM_W     = 11;  // hue numerator and 6*delta

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

endpackage

/* sv/rgb_to_hsl_converter_core.sv */
`timescale 1ns / 1ps

// RGB to HSL converter. Takes one pixel per clock with start; busy is high
// only during reset. Each result comes out in pixel order, on one cycle
// marked by done, and must be taken then. The two dividers (hue and
// saturation) work in parallel and resolve one quotient bit per pipeline
// stage over HUE_BITS+1 stages; before them lie three front stages (input
// register, extremes and sector, operands), after them one output register.
module rgb_to_hsl_converter_core
  import rhsl_pkg::*;
#(
  parameter int HUE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [23:0]         pixel,
  output logic                done,
  output logic [HUE_BITS-1:0] hue,
  output logic [7:0]          saturation,
  output logic [7:0]          lightness,
  output logic                achromatic
);

  localparam int QW = HUE_BITS + 1;

  assign busy = rst;

  // stage 1: input register
  logic            s1_valid;
  logic [CH_W-1:0] s1_r, s1_g, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= pixel[23:16];
    s1_g <= pixel[15:8];
    s1_b <= pixel[7:0];
  end

  // stage 2: extremes and sector
  logic             s2_valid;
  logic [CH_W-1:0]  s2_r, s2_g, s2_b, s2_delta;
  logic [SUM_W-1:0] s2_sum;
  sector_t          s2_sec;

  logic [CH_W-1:0]  hi, lo;
  sector_t          sec_next;

  always_comb begin
    if (s1_r >= s1_g && s1_r >= s1_b) begin
      sec_next = SEC_RED;
      hi       = s1_r;
    end else if (s1_g >= s1_b) begin
      sec_next = SEC_GREEN;
      hi       = s1_g;
    end else begin
      sec_next = SEC_BLUE;
      hi       = s1_b;
    end
    lo = (s1_r <= s1_g) ? s1_r : s1_g;
    lo = (lo <= s1_b) ? lo : s1_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r     <= s1_r;
    s2_g     <= s1_g;
    s2_b     <= s1_b;
    s2_delta <= hi - lo;
    s2_sum   <= {1'b0, hi} + {1'b0, lo};
    s2_sec   <= sec_next;
  end

  // stage 3: divider operands
  logic                  s3_valid;
  logic                  s3_gray;
  logic [7:0]            s3_light;
  logic [SAT_DIV_W+QW-1:0] s3_sat_n;
  logic [SAT_DIV_W-1:0]  s3_sat_d;
  logic [HUE_DIV_W+QW-1:0] s3_hue_n;
  logic [HUE_DIV_W-1:0]  s3_hue_d;

  logic [CH_W-1:0]  den;
  logic [16:0]      sat_num;
  logic [NUM_W-1:0] full;
  logic [11:0]      num12;
  logic [SUM_W:0]   sum_rnd;

  always_comb begin
    den = (s2_sum <= SUM_W'(255)) ? s2_sum[CH_W-1:0] : CH_W'(SUM_W'(510) - s2_sum);
    // 510*delta + den
    sat_num = {s2_delta, 9'b0} - {8'b0, s2_delta, 1'b0} + {9'b0, den};
    full    = {1'b0, s2_delta, 2'b00} + {2'b00, s2_delta, 1'b0};
    case (s2_sec)
      SEC_RED: begin
        // true modulo 6 wraps a negative fraction to the top of the turn
        if (s2_g >= s2_b) begin
          num12 = {4'b0, s2_g} - {4'b0, s2_b};
        end else begin
          num12 = {1'b0, full} + {4'b0, s2_g} - {4'b0, s2_b};
        end
      end
      SEC_GREEN: num12 = {3'b0, s2_delta, 1'b0} + {4'b0, s2_b} - {4'b0, s2_r};
      SEC_BLUE:  num12 = {2'b0, s2_delta, 2'b0} + {4'b0, s2_r} - {4'b0, s2_g};
      default:   num12 = '0;
    endcase
    sum_rnd = {1'b0, s2_sum} + (SUM_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_gray  <= (s2_delta == '0);
    s3_light <= sum_rnd[8:1];
    s3_sat_n <= {{(SAT_DIV_W+QW-17){1'b0}}, sat_num};
    s3_sat_d <= {den, 1'b0};
    s3_hue_n <= {1'b0, num12[NUM_W-1:0], {QW{1'b0}}} + {{(QW+1){1'b0}}, full};
    s3_hue_d <= {full, 1'b0};
  end

  // dividers
  logic [QW-1:0] hue_q, sat_q;

  rhsl_div #(.QW(QW), .DW(HUE_DIV_W)) u_hue_div (
    .clk      (clk),
    .dividend (s3_hue_n),
    .divisor  (s3_hue_d),
    .quotient (hue_q)
  );

  rhsl_div #(.QW(QW), .DW(SAT_DIV_W)) u_sat_div (
    .clk      (clk),
    .dividend (s3_sat_n),
    .divisor  (s3_sat_d),
    .quotient (sat_q)
  );

  // side data follows the divider stages
  logic       dl_valid [QW];
  logic       dl_gray  [QW];
  logic [7:0] dl_light [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        dl_valid[i] <= 1'b0;
      end
    end else begin
      dl_valid[0] <= s3_valid;
      for (int i = 1; i < QW; i++) begin
        dl_valid[i] <= dl_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_gray[0]  <= s3_gray;
    dl_light[0] <= s3_light;
    for (int i = 1; i < QW; i++) begin
      dl_gray[i]  <= dl_gray[i-1];
      dl_light[i] <= dl_light[i-1];
    end
  end

  // output register; a hue that rounds to a full turn wraps to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dl_valid[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    hue        <= dl_gray[QW-1] ? '0 : hue_q[HUE_BITS-1:0];
    saturation <= dl_gray[QW-1] ? '0 : sat_q[7:0];
    lightness  <= dl_light[QW-1];
    achromatic <= dl_gray[QW-1];
  end

endmodule

/* sv/rhsl_div.sv */
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
// the top DW bits of the dividend must be below the divisor
module rhsl_div #(
  parameter int QW = 13,
  parameter int DW = 12
) (
  input  logic               clk,
  input  logic [DW+QW-1:0]   dividend,
  input  logic [DW-1:0]      divisor,
  output logic [QW-1:0]      quotient
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] dv_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] dv_in;
    logic [DW+1:0] diff;
    logic          borrow;

    if (i == 0) begin : g_first
      assign rem_in = dividend[DW+QW-1:QW];
      assign low_in = dividend[QW-1:0];
      assign quo_in = '0;
      assign dv_in  = divisor;
    end else begin : g_rest
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
      assign dv_in  = dv_q[i-1];
    end

    assign diff   = {1'b0, rem_in, low_in[QW-1]} - {2'b00, dv_in};
    assign borrow = diff[DW+1];

    always_ff @(posedge clk) begin
      // partial remainder stays below the divisor, so DW bits hold it
      rem_q[i] <= borrow ? {rem_in[DW-2:0], low_in[QW-1]} : diff[DW-1:0];
      low_q[i] <= {low_in[QW-2:0], 1'b0};
      quo_q[i] <= {quo_in[QW-2:0], ~borrow};
      dv_q[i]  <= dv_in;
    end
  end

  assign quotient = quo_q[QW-1];

endmodule

/* sv/rhsl_checker.sv */
`timescale 1ns / 1ps

module rhsl_checker #(
  parameter int HUE_BITS = 12
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [HUE_BITS-1:0] hue,
  input logic [7:0]          saturation,
  input logic [7:0]          lightness,
  input logic                achromatic
);

  localparam int LAT = HUE_BITS + 5;

  // every accepted item comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item did not come out on time");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    (done && achromatic) |-> (hue == '0 && saturation == '0))
    else $error("gray item with nonzero hue or saturation");

  // any nonzero delta gives saturation of at least one
  a_color_sat: assert property (@(posedge clk) disable iff (rst)
    (done && !achromatic) |-> (saturation != '0))
    else $error("colored item with zero saturation");

  a_no_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

  // results marked by done carry no unknown bits
  a_light_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({hue, saturation, lightness, achromatic}))
    else $error("result with unknown bits");

endmodule

bind rgb_to_hsl_converter_core rhsl_checker #(.HUE_BITS(HUE_BITS)) u_rhsl_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rhsl_pkg::*;

  localparam int HUE_W     = 12;
  localparam int LATENCY   = HUE_W + 5;
  localparam int N_RANDOM  = 1500;
  localparam int CALM_TAIL = 300;
  localparam int STALL_MAX = 1000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [7:0]       sat;
    logic [7:0]       light;
    logic             gray;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending_hsl[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function hsl_t predict_hsl(logic [23:0] px);
      hsl_t    res;
      sector_t sec;
      int      r, g, b, hi, lo, delta, sum, den, s;
      longint  full, num, h;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = hi - lo;
      sum = hi + lo;
      res.light = 8'((sum + 1) >> 1);
      res.hue = '0;
      res.sat = '0;
      res.gray = (delta == 0);
      if (delta != 0) begin
        den = (sum <= 255) ? sum : 510 - sum;
        s = (510 * delta + den) / (2 * den);
        res.sat = 8'((s > 255) ? 255 : s);
        // ties go red first, then green
        if (hi == r) sec = SEC_RED;
        else if (hi == g) sec = SEC_GREEN;
        else sec = SEC_BLUE;
        full = 6 * delta;
        case (sec)
          SEC_RED: begin
            // true modulo 6 when g < b
            num = (g >= b) ? longint'(g - b) : full - longint'(b - g);
          end
          SEC_GREEN: begin
            num = 2 * delta + b - r;
          end
          default: begin
            num = 4 * delta + r - g;
          end
        endcase
        h = ((num << (HUE_W + 1)) + full) / (2 * full);
        res.hue = HUE_W'(h);
      end
      return res;
    endfunction

    function void note_pixel(logic [23:0] px);
      pending_hsl.push_back(predict_hsl(px));
    endfunction

    function void check_result(hsl_t got);
      hsl_t want;
      if (pending_hsl.size() == 0) begin
        $display("%0t: unexpected result hue=%0d sat=%0d light=%0d gray=%0d",
                 $time, got.hue, got.sat, got.light, got.gray);
        errors++;
        return;
      end
      want = pending_hsl.pop_front();
      if (got.hue !== want.hue) begin
        $display("%0t: hue mismatch expected %0d actual %0d", $time, want.hue, got.hue);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t: saturation mismatch expected %0d actual %0d",
                 $time, want.sat, got.sat);
        errors++;
      end
      if (got.light !== want.light) begin
        $display("%0t: lightness mismatch expected %0d actual %0d",
                 $time, want.light, got.light);
        errors++;
      end
      if (got.gray !== want.gray) begin
        $display("%0t: achromatic mismatch expected %0d actual %0d",
                 $time, want.gray, got.gray);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [23:0]      pixel;
  logic             done;
  logic [HUE_W-1:0] hue;
  logic [7:0]       saturation;
  logic [7:0]       lightness;
  logic             achromatic;

  hsl_scoreboard sb;
  int            stall_cycles;

  rgb_to_hsl_converter_core #(
    .HUE_BITS(HUE_W)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .hue       (hue),
    .saturation(saturation),
    .lightness (lightness),
    .achromatic(achromatic)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // acceptance, result check and watchdog
  always @(posedge clk) begin
    if (start && !busy) sb.note_pixel(pixel);
    if (done === 1'b1) sb.check_result({hue, saturation, lightness, achromatic});
    if ((start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("%0t: timeout, %0d results still pending", $time, sb.pending_hsl.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [23:0] px);
    @(negedge clk);
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    pixel <= 24'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // biased pixels: grays, pairs of equal channels and channel extremes
  function automatic logic [23:0] make_pixel();
    logic [7:0] c[3];
    int         kind;
    kind = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++) c[k] = 8'($urandom);
    if (kind < 3) begin
      c[1] = c[0];
      c[2] = c[0];
    end else if (kind < 6) begin
      c[$urandom_range(0, 2)] = c[$urandom_range(0, 2)];
    end else if (kind < 8) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 4))
          0: c[k] = 8'h00;
          1: c[k] = 8'h01;
          2: c[k] = 8'hfe;
          3: c[k] = 8'hff;
          default: ;
        endcase
      end
    end
    return {c[0], c[1], c[2]};
  endfunction

  logic [23:0] directed[$] = '{
    24'h000000, 24'hffffff, 24'h808080, 24'h010101,
    24'hff0000, 24'h00ff00, 24'h0000ff,
    24'hffff00, 24'h00ffff, 24'hff00ff, 24'hffffff,
    24'hff0001, 24'h010001, 24'h010000, 24'hfeffff,
    24'h7f8080, 24'h80807f, 24'hff00fe, 24'h00fffe,
    24'hfe00ff, 24'haa5500, 24'h55aa00, 24'h00aa55, 24'h123456
  };

  initial begin
    sb = new();
    stall_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_pixel(directed[k]);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k < N_RANDOM - CALM_TAIL && $urandom_range(0, 4) == 0) begin
        pause($urandom_range(1, 4));
      end
      send_pixel(($urandom_range(0, 1) == 0) ? 24'($urandom) : make_pixel());
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending_hsl.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rhsl_pkg.sv
sv/rhsl_div.sv
sv/rgb_to_hsl_converter_core.sv
sv/rhsl_checker.sv
tb/tb.sv
